[design/vpv_pkg.sv]
// Shared types and constants of the vertex projection block.
// Depends on nothing; every module of the block imports it.
package vpv_pkg;

  localparam int unsigned COORD_FRAC   = 16;
  localparam int unsigned MATRIX_FRAC  = 12;
  localparam int unsigned LANE_BITS    = 16;
  localparam int unsigned ROW_BITS     = 64;
  localparam int unsigned SIZE_BITS    = 16;
  localparam int unsigned ORIGIN_BITS  = 32;
  localparam int unsigned CFG_IDX_BITS = 4;
  localparam int unsigned QUEUE_DEPTH  = 4;
  // Scale factor width in the back end: size << COORD_FRAC.
  localparam int unsigned SCALE_BITS   = SIZE_BITS + COORD_FRAC;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_W_ZERO    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ROW0     = 4'd0,
    CFG_ROW1     = 4'd1,
    CFG_ROW2     = 4'd2,
    CFG_ROW3     = 4'd3,
    CFG_WIDTH    = 4'd4,
    CFG_HEIGHT   = 4'd5,
    CFG_ORIGIN   = 4'd6,
    CFG_READY    = 4'd7
  } cfg_idx_e;

  // Viewport setup seen by the back end.
  typedef struct packed {
    logic [SIZE_BITS-1:0]   width;
    logic [SIZE_BITS-1:0]   height;
    logic [ORIGIN_BITS-1:0] origin;
  } viewport_t;

endpackage

[design/vpv_front.sv]
// Front end: accepts points, runs the 4x4 matrix product and classifies each word.
// Depends on vpv_pkg.
module vpv_front #(
  parameter int unsigned CW  = 32,
  parameter int unsigned MEW = 16,
  parameter int unsigned HB  = CW + MEW - 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [CW-1:0]                point_x_i,
  input  logic signed [CW-1:0]                point_y_i,
  input  logic signed [CW-1:0]                point_z_i,
  input  logic [vpv_pkg::ROW_BITS-1:0]        row_i [4],
  input  logic                                xform_ready_i,
  input  logic                                full_i,
  output logic                                push_o,
  output vpv_pkg::status_e                    status_o,
  output logic signed [HB-1:0]                h_o [4]
);
  import vpv_pkg::*;

  localparam int unsigned PW = CW + MEW;
  localparam int unsigned TW = PW - MATRIX_FRAC;

  logic                 en;
  logic                 v1_q, v2_q;
  logic                 nr1_q;
  logic signed [PW-1:0] prod_d [4][3];
  logic signed [PW-1:0] prod_q [4][3];
  logic signed [CW-1:0] pt [3];
  logic signed [HB-1:0] h_d [4];
  logic signed [HB-1:0] h_q [4];
  status_e              st_d, st_q;

  // Stall only when a finished word cannot enter the queue.
  assign en         = !(v2_q && full_i);
  assign in_ready_o = en;
  assign push_o     = v2_q && !full_i;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(row_i[r][c*LANE_BITS +: MEW]) * pt[c];
      end
    end
  end

  // Floor each product to Q16.16 and add the constant column.
  always_comb begin
    logic signed [PW-1:0]  sh;
    logic signed [MEW-1:0] e3;
    for (int r = 0; r < 4; r++) begin
      e3     = $signed(row_i[r][3*LANE_BITS +: MEW]);
      h_d[r] = HB'(e3) <<< (COORD_FRAC - MATRIX_FRAC);
      for (int c = 0; c < 3; c++) begin
        sh     = prod_q[r][c] >>> MATRIX_FRAC;
        h_d[r] = h_d[r] + HB'($signed(sh[TW-1:0]));
      end
    end
  end

  always_comb begin
    if (nr1_q) begin
      st_d = ST_NOT_READY;
    end else if (h_d[3] == '0) begin
      st_d = ST_W_ZERO;
    end else begin
      st_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      nr1_q  <= !xform_ready_i;
      h_q    <= h_d;
      st_q   <= st_d;
    end
  end

  assign status_o = st_q;
  assign h_o      = h_q;

endmodule

[design/vpv_fifo.sv]
// Short queue between front and back end.
// Depends on vpv_pkg only for the house import style.
module vpv_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o
);
  import vpv_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[design/vpv_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on vpv_pkg only for the house import style.
module vpv_div #(
  parameter int unsigned NW = 71,
  parameter int unsigned DW = 39,
  parameter int unsigned QW = 50
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quot_o
);
  import vpv_pkg::*;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];

  // Quotient too large for QW bits: flag it and saturate at the end.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (num_i >> QW) >= NW'(den_i);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned B = QW - 1 - k;
    logic fits;

    assign fits = (rem_q[k] >> B) >= NW'(den_q[k]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k+1] <= quo_q[k] | (fits ? (QW'(1) << B) : '0);
        ovf_q[k+1] <= ovf_q[k];
      end
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= fits ? rem_q[k] - (NW'(den_q[k]) << B) : rem_q[k];
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  assign quot_o = ovf_q[QW] ? '1 : quo_q[QW];

endmodule

[design/vpv_back.sv]
// Back end: perspective divide, viewport mapping, saturation and output register.
// Depends on vpv_pkg and vpv_div.
module vpv_back #(
  parameter int unsigned CW = 32,
  parameter int unsigned HB = 38
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_valid_i,
  output logic                   pop_o,
  input  vpv_pkg::status_e       rd_status_i,
  input  logic signed [HB-1:0]   rd_h_i [4],
  input  vpv_pkg::viewport_t     vp_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [CW-1:0]   win_x_o,
  output logic signed [CW-1:0]   win_y_o,
  output logic signed [CW-1:0]   win_z_o,
  output vpv_pkg::status_e       status_o
);
  import vpv_pkg::*;

  localparam int unsigned NW = HB + 1 + SCALE_BITS;
  localparam int unsigned DW = HB + 1;
  localparam int unsigned QW = CW + 18;
  localparam int unsigned L  = QW + 1;
  localparam int unsigned VW = QW + 2;

  logic                 en;
  logic                 v0_q;
  status_e              st0_q;
  logic [2:0]           neg0_q;
  logic [NW-1:0]        num_d [3];
  logic [NW-1:0]        num_q [3];
  logic [DW-1:0]        den_d [3];
  logic [DW-1:0]        den_q [3];
  logic [2:0]           neg_d;
  logic [QW-1:0]        quot [3];
  logic                 vl_q  [L];
  status_e              stl_q [L];
  logic [2:0]           negl_q [L];
  logic signed [CW-1:0] win_d [3];
  logic signed [CW-1:0] win_q [3];
  logic                 ov_q;
  status_e              sto_q;

  // Advance the whole back pipeline whenever the output register frees up.
  assign en    = !ov_q || out_ready_i;
  assign pop_o = en && rd_valid_i;

  always_comb begin
    logic signed [HB:0]   s;
    logic [HB:0]          ms;
    logic [HB-1:0]        mw;
    logic [SCALE_BITS-1:0] scale;
    mw = rd_h_i[3][HB-1] ? HB'(-rd_h_i[3]) : HB'(rd_h_i[3]);
    for (int c = 0; c < 3; c++) begin
      s        = (HB+1)'(rd_h_i[c]) + (HB+1)'(rd_h_i[3]);
      ms       = s[HB] ? (HB+1)'(-s) : (HB+1)'(s);
      neg_d[c] = s[HB] ^ rd_h_i[3][HB-1];
      if (c == 2) begin
        num_d[c] = NW'(ms) << (COORD_FRAC - 1);
        den_d[c] = {1'b0, mw};
      end else begin
        scale    = (c == 0) ? {vp_i.width, COORD_FRAC'(0)} : {vp_i.height, COORD_FRAC'(0)};
        num_d[c] = NW'(ms) * NW'(scale);
        den_d[c] = {mw, 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q  <= num_d;
      den_q  <= den_d;
      neg0_q <= neg_d;
      st0_q  <= rd_status_i;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    vpv_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num_q[c]),
      .den_i  (den_q[c]),
      .quot_o (quot[c])
    );
  end

  // Sideband line matched to the divider latency.
  always_ff @(posedge clk_i) begin
    if (en) begin
      stl_q[0]  <= st0_q;
      negl_q[0] <= neg0_q;
      for (int k = 1; k < L; k++) begin
        stl_q[k]  <= stl_q[k-1];
        negl_q[k] <= negl_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      for (int k = 0; k < L; k++) begin
        vl_q[k] <= 1'b0;
      end
      ov_q <= 1'b0;
    end else if (en) begin
      v0_q    <= rd_valid_i;
      vl_q[0] <= v0_q;
      for (int k = 1; k < L; k++) begin
        vl_q[k] <= vl_q[k-1];
      end
      ov_q <= vl_q[L-1];
    end
  end

  always_comb begin
    logic signed [QW:0]   q;
    logic signed [VW-1:0] v;
    logic [SIZE_BITS-1:0] org;
    for (int c = 0; c < 3; c++) begin
      q   = negl_q[L-1][c] ? -$signed({1'b0, quot[c]}) : $signed({1'b0, quot[c]});
      org = (c == 0) ? vp_i.origin[SIZE_BITS-1:0] : vp_i.origin[2*SIZE_BITS-1:SIZE_BITS];
      v   = VW'(q);
      if (c != 2) begin
        v = v + $signed(VW'({org, COORD_FRAC'(0)}));
      end
      if (stl_q[L-1] != ST_OK) begin
        win_d[c] = '0;
      end else if (v > $signed(VW'({1'b0, {(CW-1){1'b1}}}))) begin
        win_d[c] = {1'b0, {(CW-1){1'b1}}};
      end else if (v < -$signed(VW'({1'b1, {(CW-1){1'b0}}}))) begin
        win_d[c] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        win_d[c] = v[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      win_q <= win_d;
      sto_q <= stl_q[L-1];
    end
  end

  assign out_valid_o = ov_q;
  assign win_x_o     = win_q[0];
  assign win_y_o     = win_q[1];
  assign win_z_o     = win_q[2];
  assign status_o    = sto_q;

endmodule

[design/vertex_project_to_viewport.sv]
// Top level of the vertex projection block: configuration registers and wiring.
// Depends on vpv_pkg, vpv_front, vpv_fifo, vpv_back (and vpv_div below it).
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one world point per word
//   (point_x_i, point_y_i, point_z_i, signed Q16.16). Output channel
//   out_valid_o/out_ready_i returns win_x_o, win_y_o, win_z_o and status_o.
//   Configuration words arrive on cfg_valid_i/cfg_ready_o with cfg_index_i
//   selecting the register (matrix rows 0..3, width, height, origin, ready);
//   cfg_ready_o is always high and unknown indexes are dropped. Write them
//   only while no point is in flight.
//   Throughput: one point per cycle while the receiver holds out_ready_i
//   high. Most of the pipeline is the divider, which resolves one quotient
//   bit per stage over COORD_WIDTH + 18 stages.
//   Front end: two stages (matrix products, sums and classification), then a
//   four-word queue; back end: scaling multiply, divider, output register.
//   Receiver stall: the back end freezes and the queue fills; the front end
//   freezes only when the queue is full, then in_ready_o drops.
//   Reset clears all configuration (transform not ready) and all valid bits.
module vertex_project_to_viewport #(
  parameter int unsigned COORD_WIDTH        = 32,
  parameter int unsigned MATRIX_ENTRY_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]        point_x_i,
  input  logic signed [COORD_WIDTH-1:0]        point_y_i,
  input  logic signed [COORD_WIDTH-1:0]        point_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [COORD_WIDTH-1:0]        win_x_o,
  output logic signed [COORD_WIDTH-1:0]        win_y_o,
  output logic signed [COORD_WIDTH-1:0]        win_z_o,
  output vpv_pkg::status_e                     status_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [vpv_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [vpv_pkg::ROW_BITS-1:0]         cfg_data_i
);
  import vpv_pkg::*;

  // Width of one homogeneous component.
  localparam int unsigned HB = COORD_WIDTH + MATRIX_ENTRY_WIDTH - 10;
  localparam int unsigned FW = 2 + 4 * HB;

  logic [ROW_BITS-1:0]  row_q [4];
  viewport_t            vp_q;
  logic                 xready_q;

  logic                 push, pop, full, empty;
  status_e              f_status;
  logic signed [HB-1:0] f_h [4];
  logic [FW-1:0]        wdata, rdata;
  status_e              b_status;
  logic signed [HB-1:0] b_h [4];

  // Configuration registers: a write takes effect from the next cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) begin
        row_q[r] <= '0;
      end
      vp_q     <= '0;
      xready_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROW0:   row_q[0]  <= cfg_data_i;
        CFG_ROW1:   row_q[1]  <= cfg_data_i;
        CFG_ROW2:   row_q[2]  <= cfg_data_i;
        CFG_ROW3:   row_q[3]  <= cfg_data_i;
        CFG_WIDTH:  vp_q.width  <= cfg_data_i[SIZE_BITS-1:0];
        CFG_HEIGHT: vp_q.height <= cfg_data_i[SIZE_BITS-1:0];
        CFG_ORIGIN: vp_q.origin <= cfg_data_i[ORIGIN_BITS-1:0];
        CFG_READY:  xready_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  vpv_front #(.CW(COORD_WIDTH), .MEW(MATRIX_ENTRY_WIDTH), .HB(HB)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .row_i         (row_q),
    .xform_ready_i (xready_q),
    .full_i        (full),
    .push_o        (push),
    .status_o      (f_status),
    .h_o           (f_h)
  );

  // Pack the classified word for the queue.
  assign wdata = {f_status, f_h[0], f_h[1], f_h[2], f_h[3]};

  vpv_fifo #(.W(FW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .pop_i   (pop),
    .rdata_o (rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  assign b_status = status_e'(rdata[FW-1 -: 2]);
  assign b_h[0]   = $signed(rdata[4*HB-1 -: HB]);
  assign b_h[1]   = $signed(rdata[3*HB-1 -: HB]);
  assign b_h[2]   = $signed(rdata[2*HB-1 -: HB]);
  assign b_h[3]   = $signed(rdata[HB-1:0]);

  vpv_back #(.CW(COORD_WIDTH), .HB(HB)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_valid_i  (!empty),
    .pop_o       (pop),
    .rd_status_i (b_status),
    .rd_h_i      (b_h),
    .vp_i        (vp_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .win_x_o     (win_x_o),
    .win_y_o     (win_y_o),
    .win_z_o     (win_z_o),
    .status_o    (status_o)
  );

  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NOT_READY |->
      win_x_o == '0 && win_y_o == '0 && win_z_o == '0)
    else $error("not-ready result carries nonzero coordinates");

  a_w_zero_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_W_ZERO |->
      win_x_o == '0 && win_y_o == '0 && win_z_o == '0)
    else $error("zero-w result carries nonzero coordinates");

  a_front_stall_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> full)
    else $error("front end stalled with room in the queue");

endmodule

[tb/vpv_checker.sv]
// Checker for vertex_project_to_viewport: tracks configuration words, predicts each
// projected point and compares the output words field by field. Depends on vpv_pkg.
`timescale 1ns / 1ps

module vpv_checker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic signed [COORD_WIDTH-1:0]    point_x_i,
  input  logic signed [COORD_WIDTH-1:0]    point_y_i,
  input  logic signed [COORD_WIDTH-1:0]    point_z_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [COORD_WIDTH-1:0]    win_x_i,
  input  logic signed [COORD_WIDTH-1:0]    win_y_i,
  input  logic signed [COORD_WIDTH-1:0]    win_z_i,
  input  vpv_pkg::status_e                 status_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [vpv_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [vpv_pkg::ROW_BITS-1:0]     cfg_data_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  import vpv_pkg::*;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] win_x;
    logic signed [COORD_WIDTH-1:0] win_y;
    logic signed [COORD_WIDTH-1:0] win_z;
    status_e                       status;
  } window_word_t;

  localparam logic [127:0] QUOT_CAP = 128'd1 << 62;

  logic [ROW_BITS-1:0]    mat_rows [4];
  logic [SIZE_BITS-1:0]   vp_width;
  logic [SIZE_BITS-1:0]   vp_height;
  logic [ORIGIN_BITS-1:0] vp_origin;
  logic                   xf_ready;
  window_word_t           window_q [$];
  int                     fails;

  assign fail_count_o = fails;
  assign pending_o    = window_q.size();

  function automatic logic signed [127:0] row_sum(logic [ROW_BITS-1:0] row,
                                                  logic signed [127:0] pt [4]);
    logic signed [127:0] acc;
    logic signed [127:0] ent;
    logic signed [127:0] prod;
    acc = 0;
    for (int c = 0; c < 4; c++) begin
      ent  = $signed(row[c*LANE_BITS +: 16]);
      prod = ent * pt[c];
      acc  = acc + (prod >>> MATRIX_FRAC);  // floor to Q16.16
    end
    return acc;
  endfunction

  // trunc(s * mult / (hw << dshift)) with the magnitude capped at 2^62
  function automatic logic signed [127:0] div_scaled(logic signed [127:0] s,
                                                     logic signed [127:0] hw,
                                                     logic [127:0] mult, int dshift);
    logic [127:0] ms;
    logic [127:0] mw;
    logic [127:0] q;
    ms = (s < 0) ? -s : s;
    mw = (hw < 0) ? -hw : hw;
    q  = (ms * mult) / (mw << dshift);
    if (q > QUOT_CAP) q = QUOT_CAP;
    return ((s < 0) != (hw < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(logic signed [127:0] v);
    logic signed [127:0] top;
    logic signed [127:0] bot;
    top = (128'sd1 <<< (COORD_WIDTH - 1)) - 1;
    bot = -top - 1;
    if (v > top) v = top;
    if (v < bot) v = bot;
    return v[COORD_WIDTH-1:0];
  endfunction

  function automatic window_word_t project_point(logic signed [COORD_WIDTH-1:0] px,
                                                 logic signed [COORD_WIDTH-1:0] py,
                                                 logic signed [COORD_WIDTH-1:0] pz);
    window_word_t        w;
    logic signed [127:0] pt [4];
    logic signed [127:0] hx, hy, hz, hw;
    logic signed [127:0] ox, oy;
    w.win_x = '0;
    w.win_y = '0;
    w.win_z = '0;
    if (!xf_ready) begin
      w.status = ST_NOT_READY;
      return w;
    end
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    pt[3] = 128'sd1 <<< COORD_FRAC;
    hx = row_sum(mat_rows[0], pt);
    hy = row_sum(mat_rows[1], pt);
    hz = row_sum(mat_rows[2], pt);
    hw = row_sum(mat_rows[3], pt);
    if (hw == 0) begin
      w.status = ST_W_ZERO;
      return w;
    end
    ox = $signed({112'd0, vp_origin[15:0]}) <<< COORD_FRAC;
    oy = $signed({112'd0, vp_origin[31:16]}) <<< COORD_FRAC;
    w.win_x  = sat_coord(div_scaled(hx + hw, hw, {112'd0, vp_width} << COORD_FRAC, 1) + ox);
    w.win_y  = sat_coord(div_scaled(hy + hw, hw, {112'd0, vp_height} << COORD_FRAC, 1) + oy);
    w.win_z  = sat_coord(div_scaled(hz + hw, hw, 128'd1 << (COORD_FRAC - 1), 0));
    w.status = ST_OK;
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    window_word_t want;
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) mat_rows[r] = '0;
      vp_width  = '0;
      vp_height = '0;
      vp_origin = '0;
      xf_ready  = 1'b0;
      fails     = 0;
      window_q.delete();
    end else begin
      // Compare first: an output word never depends on an input taken this edge.
      if (out_valid_i && out_ready_i) begin
        if (window_q.size() == 0) begin
          report_mismatch("unexpected word", {win_x_i, win_y_i}, '0);
        end else begin
          want = window_q.pop_front();
          if (win_x_i !== want.win_x) report_mismatch("win_x", win_x_i, want.win_x);
          if (win_y_i !== want.win_y) report_mismatch("win_y", win_y_i, want.win_y);
          if (win_z_i !== want.win_z) report_mismatch("win_z", win_z_i, want.win_z);
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
        end
      end
      if (in_valid_i && in_ready_i)
        window_q.push_back(project_point(point_x_i, point_y_i, point_z_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ROW0:   mat_rows[0] = cfg_data_i;
          CFG_ROW1:   mat_rows[1] = cfg_data_i;
          CFG_ROW2:   mat_rows[2] = cfg_data_i;
          CFG_ROW3:   mat_rows[3] = cfg_data_i;
          CFG_WIDTH:  vp_width  = cfg_data_i[SIZE_BITS-1:0];
          CFG_HEIGHT: vp_height = cfg_data_i[SIZE_BITS-1:0];
          CFG_ORIGIN: vp_origin = cfg_data_i[ORIGIN_BITS-1:0];
          CFG_READY:  xf_ready  = cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

[tb/tb_vertex_project_to_viewport.sv]
// Top of the vertex projection testbench: clock, reset, configuration and point stimulus.
// Depends on vpv_pkg, vertex_project_to_viewport and vpv_checker.
`timescale 1ns / 1ps

module tb_vertex_project_to_viewport;
  import vpv_pkg::*;

  localparam int unsigned CW          = 32;
  localparam int          DRAIN       = 80;      // longer than the accept-to-output latency
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_ITEMS = 166;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [CW-1:0]    pt_x, pt_y, pt_z;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [CW-1:0]    win_x, win_y, win_z;
  status_e                 status;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [ROW_BITS-1:0]     cfg_data;
  int                      fail_count;
  int                      pending;

  int  gap_pct;    // chance the sender idles in a cycle
  int  stall_pct;  // chance the receiver stalls in a cycle
  logic hold_off;  // long receiver hold-off, set by its own process
  int  cycles;

  vertex_project_to_viewport uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .point_x_i   (pt_x),
    .point_y_i   (pt_y),
    .point_z_i   (pt_z),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .win_x_o     (win_x),
    .win_y_o     (win_y),
    .win_z_o     (win_z),
    .status_o    (status),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  vpv_checker #(.COORD_WIDTH(CW)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .point_x_i    (pt_x),
    .point_y_i    (pt_y),
    .point_z_i    (pt_z),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .win_x_i      (win_x),
    .win_y_i      (win_y),
    .win_z_i      (win_z),
    .status_i     (status),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Receiver: stall at random unless a long hold-off is running.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[vertex_project_to_viewport] ERROR");
      $finish;
    end
  end

  // Hold a word until the edge where ready, sampled mid-cycle, was high.
  task automatic wait_accept(ref logic rdy);
    logic seen;
    forever begin
      @(negedge clk_i);
      seen = rdy;
      @(posedge clk_i);
      if (seen) break;
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [ROW_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    wait_accept(cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Drain every expected word plus the pipeline depth before touching registers.
  task automatic wait_idle();
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // Idle the sender cycle by cycle, then offer the word until it is taken.
  task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    pt_x     <= x;
    pt_y     <= y;
    pt_z     <= z;
    wait_accept(in_ready);
  endtask

  function automatic logic [63:0] pack_row(logic [15:0] e0, logic [15:0] e1,
                                           logic [15:0] e2, logic [15:0] e3);
    return {e3, e2, e1, e0};
  endfunction

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(16'h2000));   // modest, near identity
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($signed($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000);
      3:       return 32'($signed($urandom_range(32'h0FFF_FFFF)) - 32'sh0800_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic set_viewport(logic [15:0] w, logic [15:0] h, logic [31:0] org);
    write_reg(CFG_WIDTH, 64'(w));
    write_reg(CFG_HEIGHT, 64'(h));
    write_reg(CFG_ORIGIN, 64'(org));
  endtask

  initial begin
    logic [15:0] w3;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    pt_x      = '0;
    pt_y      = '0;
    pt_z      = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    hold_off  = 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    cycles    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Not ready after reset: every point gives zeros.
    send_point('0, '0, '0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    in_valid <= 1'b0;
    wait_idle();

    // Identity matrix, w = 1.
    write_reg(CFG_ROW0, pack_row(16'h1000, 16'h0000, 16'h0000, 16'h0000));
    write_reg(CFG_ROW1, pack_row(16'h0000, 16'h1000, 16'h0000, 16'h0000));
    write_reg(CFG_ROW2, pack_row(16'h0000, 16'h0000, 16'h1000, 16'h0000));
    write_reg(CFG_ROW3, pack_row(16'h0000, 16'h0000, 16'h0000, 16'h1000));
    set_viewport(16'd640, 16'd480, {16'd100, 16'd50});
    write_reg(CFG_READY, 64'd1);
    write_reg(cfg_idx_e'(4'd15), '1);   // unknown index, dropped
    send_point('0, '0, '0);
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0000_4000, 32'hFFFF_C000, 32'hFFFF_FFFF);
    in_valid <= 1'b0;
    wait_idle();

    // Zero w from a zero last row, then w = z.
    write_reg(CFG_ROW3, '0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    in_valid <= 1'b0;
    wait_idle();
    write_reg(CFG_ROW3, pack_row(16'h0000, 16'h0000, 16'h1000, 16'h0000));
    send_point(32'h0001_0000, 32'h0001_0000, '0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
    send_point(32'h0005_0000, 32'hFFFB_0000, 32'hFFFF_0000);
    in_valid <= 1'b0;
    wait_idle();

    // Zero viewport: window lands on the origin.
    set_viewport(16'd0, 16'd0, 32'hFFFF_FFFF);
    send_point(32'h0001_0000, 32'h0003_0000, 32'h0002_0000);
    send_point(32'h1234_5678, 32'h8765_4321, 32'h0001_0000);
    in_valid <= 1'b0;
    wait_idle();

    // Extreme matrix and viewport: drive saturation.
    write_reg(CFG_ROW0, {4{16'h7FFF}});
    write_reg(CFG_ROW1, {4{16'h8000}});
    write_reg(CFG_ROW2, pack_row(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
    write_reg(CFG_ROW3, pack_row(16'h0000, 16'h0000, 16'h0001, 16'h0001));
    set_viewport(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
    send_point(32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
    send_point(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFF0_0000);
    in_valid <= 1'b0;
    wait_idle();

    // Random phases, cycling through the idling patterns.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 50; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 21; stall_pct = 21; end
      endcase
      write_reg(CFG_ROW0, pack_row(rand_entry(), rand_entry(), rand_entry(), rand_entry()));
      write_reg(CFG_ROW1, pack_row(rand_entry(), rand_entry(), rand_entry(), rand_entry()));
      write_reg(CFG_ROW2, pack_row(rand_entry(), rand_entry(), rand_entry(), rand_entry()));
      // Keep the w row's x and y entries small and its constant term mostly large so divides are tame.
      w3 = ($urandom_range(3) == 0) ? rand_entry() : 16'($urandom_range(16'h7FFF, 16'h0400));
      write_reg(CFG_ROW3, pack_row(16'($urandom_range(255)), rand_entry() & 16'h00FF,
                                   16'($urandom), w3));
      case (ph % 3)
        0:       set_viewport(16'hFFFF, 16'hFFFF, $urandom);
        1:       set_viewport(16'd0, 16'($urandom), 32'd0);
        default: set_viewport(16'($urandom), 16'($urandom), $urandom);
      endcase
      write_reg(CFG_READY, (ph == 5) ? 64'd0 : 64'd1);
      // Fill the block: hold the receiver off while points keep coming.
      if (ph == 0) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off <= 1'b0;
          end
        join_none
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_point(rand_coord(), rand_coord(),
                   ($urandom_range(9) == 0) ? '0 : rand_coord());
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("[vertex_project_to_viewport] OK");
    end else begin
      $display("[vertex_project_to_viewport] ERROR");
    end
    $finish;
  end

endmodule
